/* hdl/tsd_pkg.sv */
`default_nettype none

package tsd_pkg;

    localparam int TableEntries = 64;
    localparam int AddrW        = $clog2(TableEntries);
    localparam int EntryW       = 16;

    localparam logic [7:0] RAW_OPCODE   = 8'hFF;
    localparam logic [1:0] OP_LOOKUP    = 2'd0;
    localparam logic [1:0] OP_DIFF      = 2'd1;
    localparam logic [1:0] OP_RAMP      = 2'd2;
    localparam logic [1:0] OP_RUN       = 2'd3;
    localparam logic [2:0] HEADER_BYTES = 3'd4;
    localparam logic [2:0] HDR_SIZE_LO  = 3'd1;
    localparam logic [2:0] HDR_SIZE_MID = 3'd2;
    localparam logic [2:0] HDR_SIZE_HI  = 3'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
        logic       stream_end;
    } byte_item_t;

    typedef struct packed {
        logic [EntryW-1:0] tile_entry;
        logic              end_of_group;
        logic              status_item;
        logic              count_mismatch;
    } result_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_REPEAT,
        S_STATUS
    } state_t;

    typedef enum logic [1:0] {
        RAW_NONE,
        RAW_LOW,
        RAW_HIGH
    } raw_phase_t;

    typedef enum logic [3:0] {
        K_HEADER,
        K_RAW_LOW,
        K_RAW_HIGH,
        K_SKIP,
        K_RAW_OPEN,
        K_INDEX,
        K_DIFF,
        K_SLIDE,
        K_RUN
    } kind_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic step;
        logic status;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  end_seen;
        logic  out_free;
        logic  step_last;
    } dp_stat_t;

    function automatic logic [AddrW-1:0] hash_of(input logic [EntryW-1:0] e);
        logic [AddrW-1:0] mid;
        logic [AddrW-1:0] hi;
        mid = AddrW'(e[11:10]) * AddrW'(3);
        hi  = AddrW'(e[15:12]) * AddrW'(5);
        return e[AddrW-1:0] + mid + hi;
    endfunction

endpackage

`default_nettype wire

/* hdl/tilemap_stream_decoder.sv */
// channel   signals                                  carries
// byte      byte_valid, byte_stall, byte_data        one compressed stream byte and marks
// result    result_valid, result_stall, result       one tile entry or the end status
//
// each byte is captured in the idle state and decoded in the decode state, which waits for a free result
// run and slide opcodes then add one repeat state step per entry, n+1 steps
// a byte marked as stream end then passes through the status state for the status item
// the capture cycle is set by the registered read of the 64-entry hash table
// rst_n clears control state and table valid bits; a captured stream_start clears the valid bits and stream state
// a stalled valid result holds the decoder in its emitting state; byte_stall is high outside idle
`default_nettype none

module tilemap_stream_decoder #(
    parameter int COUNT_WIDTH = 23
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire tsd_pkg::byte_item_t   byte_data,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output tsd_pkg::result_item_t      result
);

    tsd_pkg::dp_cmd_t  cmd;
    tsd_pkg::dp_stat_t stat;

    tsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tsd_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_data    (byte_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

/* hdl/tsd_ctrl.sv */
`default_nettype none

module tsd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire tsd_pkg::dp_stat_t stat,
    output tsd_pkg::dp_cmd_t       cmd
);

    tsd_pkg::state_t state_reg;
    tsd_pkg::state_t state_next;
    logic            needs_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign needs_out = (stat.kind == tsd_pkg::K_RAW_HIGH) ||
                       (stat.kind == tsd_pkg::K_INDEX) ||
                       (stat.kind == tsd_pkg::K_DIFF);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        byte_stall = 1'b1;
        case (state_reg)
            tsd_pkg::S_IDLE:
            begin
                byte_stall = 1'b0;
                if (byte_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tsd_pkg::S_DECODE;
                end
            end
            tsd_pkg::S_DECODE:
            begin
                if (!needs_out || stat.out_free)
                begin
                    cmd.decode = 1'b1;
                    if (stat.kind == tsd_pkg::K_SLIDE || stat.kind == tsd_pkg::K_RUN)
                    begin
                        state_next = tsd_pkg::S_REPEAT;
                    end
                    else if (stat.end_seen)
                    begin
                        state_next = tsd_pkg::S_STATUS;
                    end
                    else
                    begin
                        state_next = tsd_pkg::S_IDLE;
                    end
                end
            end
            tsd_pkg::S_REPEAT:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.step_last)
                    begin
                        state_next = stat.end_seen ? tsd_pkg::S_STATUS : tsd_pkg::S_IDLE;
                    end
                end
            end
            tsd_pkg::S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.status = 1'b1;
                    state_next = tsd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tsd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/tsd_datapath.sv */
`default_nettype none

module tsd_datapath #(
    parameter int COUNT_WIDTH = 23
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tsd_pkg::byte_item_t   byte_data,
    input  wire tsd_pkg::dp_cmd_t      cmd,
    output tsd_pkg::dp_stat_t          stat,
    input  wire logic                  result_stall,
    output logic                       result_valid,
    output tsd_pkg::result_item_t      result
);

    localparam int EW = tsd_pkg::EntryW;
    localparam int AW = tsd_pkg::AddrW;

    logic [7:0]             byte_reg;
    logic                   end_reg;
    logic [EW-1:0]          last_reg, last_next;
    logic [2:0]             hdr_idx_reg, hdr_idx_next;
    logic [COUNT_WIDTH-1:0] declared_reg, declared_next;
    logic [COUNT_WIDTH-1:0] emitted_reg, emitted_next;
    tsd_pkg::raw_phase_t    raw_phase_reg, raw_phase_next;
    logic [7:0]             raw_low_reg, raw_low_next;
    logic                   overran_reg, overran_next;
    logic [5:0]             rep_cnt_reg, rep_cnt_next;
    logic                   rep_slide_reg, rep_slide_next;
    logic                   rep_down_reg, rep_down_next;
    tsd_pkg::result_item_t  out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [EW-1:0]                   tbl_mem [tsd_pkg::TableEntries];
    logic [tsd_pkg::TableEntries-1:0] tbl_valid_reg;
    logic [EW-1:0]                   rdata_reg;

    tsd_pkg::kind_t         kind;
    logic                   count_open;
    logic [COUNT_WIDTH-1:0] emitted_inc;
    logic                   out_free;
    logic [EW-1:0]          diff_val;
    logic [EW-1:0]          single_val;
    logic [EW-1:0]          step_val;
    logic [EW-1:0]          entry_val;
    logic                   emit;
    logic                   final_step;
    logic                   tbl_we;
    logic [AW-1:0]          tbl_waddr;
    logic [23:0]            size_part;

    assign count_open  = emitted_reg < declared_reg;
    assign emitted_inc = emitted_reg + 1'b1;
    assign out_free    = !out_valid_reg || !result_stall;
    assign diff_val    = (last_reg + EW'(byte_reg[3:0]) - EW'(8)) ^
                         {4'b0000, byte_reg[5:4], 10'b0};
    assign step_val    = !rep_slide_reg ? last_reg :
                         (rep_down_reg ? last_reg - 1'b1 : last_reg + 1'b1);
    assign tbl_waddr   = tsd_pkg::hash_of(entry_val);

    always_comb
    begin
        if (hdr_idx_reg < tsd_pkg::HEADER_BYTES)
        begin
            kind = tsd_pkg::K_HEADER;
        end
        else if (raw_phase_reg == tsd_pkg::RAW_LOW)
        begin
            kind = tsd_pkg::K_RAW_LOW;
        end
        else if (raw_phase_reg == tsd_pkg::RAW_HIGH)
        begin
            kind = tsd_pkg::K_RAW_HIGH;
        end
        else if (!count_open)
        begin
            kind = tsd_pkg::K_SKIP;
        end
        else if (byte_reg == tsd_pkg::RAW_OPCODE)
        begin
            kind = tsd_pkg::K_RAW_OPEN;
        end
        else
        begin
            case (byte_reg[7:6])
                tsd_pkg::OP_LOOKUP: kind = tsd_pkg::K_INDEX;
                tsd_pkg::OP_DIFF:   kind = tsd_pkg::K_DIFF;
                tsd_pkg::OP_RAMP:   kind = tsd_pkg::K_SLIDE;
                default:            kind = tsd_pkg::K_RUN;
            endcase
        end
    end

    always_comb
    begin
        case (kind)
            tsd_pkg::K_RAW_HIGH: single_val = {byte_reg, raw_low_reg};
            tsd_pkg::K_INDEX:    single_val = tbl_valid_reg[byte_reg[AW-1:0]] ? rdata_reg : '0;
            tsd_pkg::K_DIFF:     single_val = diff_val;
            default:             single_val = last_reg;
        endcase
    end

    always_comb
    begin
        case (hdr_idx_reg)
            tsd_pkg::HDR_SIZE_LO:  size_part = {17'b0, byte_reg[7:1]};
            tsd_pkg::HDR_SIZE_MID: size_part = {9'b0, byte_reg, 7'b0};
            tsd_pkg::HDR_SIZE_HI:  size_part = {1'b0, byte_reg, 15'b0};
            default:               size_part = '0;
        endcase
    end

    always_comb
    begin
        last_next      = last_reg;
        hdr_idx_next   = hdr_idx_reg;
        declared_next  = declared_reg;
        emitted_next   = emitted_reg;
        raw_phase_next = raw_phase_reg;
        raw_low_next   = raw_low_reg;
        overran_next   = overran_reg;
        rep_cnt_next   = rep_cnt_reg;
        rep_slide_next = rep_slide_reg;
        rep_down_next  = rep_down_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        entry_val      = single_val;
        emit           = 1'b0;
        final_step     = 1'b1;
        tbl_we         = 1'b0;

        if (cmd.capture && byte_data.stream_start)
        begin
            last_next      = '0;
            hdr_idx_next   = '0;
            declared_next  = '0;
            emitted_next   = '0;
            raw_phase_next = tsd_pkg::RAW_NONE;
            overran_next   = 1'b0;
        end

        if (cmd.decode)
        begin
            case (kind)
                tsd_pkg::K_HEADER:
                begin
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == tsd_pkg::HDR_SIZE_LO)
                    begin
                        declared_next = size_part[COUNT_WIDTH-1:0];
                    end
                    else
                    begin
                        declared_next = declared_reg | size_part[COUNT_WIDTH-1:0];
                    end
                end
                tsd_pkg::K_RAW_LOW:
                begin
                    raw_low_next   = byte_reg;
                    raw_phase_next = tsd_pkg::RAW_HIGH;
                end
                tsd_pkg::K_RAW_HIGH:
                begin
                    raw_phase_next = tsd_pkg::RAW_NONE;
                    last_next      = single_val;
                    tbl_we         = 1'b1;
                    emit           = 1'b1;
                end
                tsd_pkg::K_RAW_OPEN:
                begin
                    raw_phase_next = tsd_pkg::RAW_LOW;
                end
                tsd_pkg::K_INDEX:
                begin
                    last_next = single_val;
                    emit      = 1'b1;
                end
                tsd_pkg::K_DIFF:
                begin
                    last_next = single_val;
                    tbl_we    = 1'b1;
                    emit      = 1'b1;
                end
                tsd_pkg::K_SLIDE:
                begin
                    rep_cnt_next   = {1'b0, byte_reg[4:0]};
                    rep_slide_next = 1'b1;
                    rep_down_next  = byte_reg[5];
                end
                tsd_pkg::K_RUN:
                begin
                    rep_cnt_next   = byte_reg[5:0];
                    rep_slide_next = 1'b0;
                    rep_down_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.step)
        begin
            entry_val    = step_val;
            last_next    = step_val;
            tbl_we       = rep_slide_reg;
            emit         = 1'b1;
            final_step   = (rep_cnt_reg == '0);
            rep_cnt_next = rep_cnt_reg - 1'b1;
        end

        if (emit)
        begin
            if (count_open)
            begin
                out_next.tile_entry     = entry_val;
                out_next.end_of_group   = !end_reg &&
                                          (final_step || emitted_inc == declared_reg);
                out_next.status_item    = 1'b0;
                out_next.count_mismatch = 1'b0;
                out_valid_next          = 1'b1;
                emitted_next            = emitted_inc;
            end
            else
            begin
                overran_next = 1'b1;
            end
        end

        if (cmd.status)
        begin
            out_next.tile_entry     = '0;
            out_next.end_of_group   = 1'b1;
            out_next.status_item    = 1'b1;
            out_next.count_mismatch = (emitted_reg != declared_reg) || overran_reg;
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            hdr_idx_reg   <= '0;
            declared_reg  <= '0;
            emitted_reg   <= '0;
            raw_phase_reg <= tsd_pkg::RAW_NONE;
            raw_low_reg   <= '0;
            overran_reg   <= 1'b0;
            rep_cnt_reg   <= '0;
            rep_slide_reg <= 1'b0;
            rep_down_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tbl_valid_reg <= '0;
        end
        else
        begin
            last_reg      <= last_next;
            hdr_idx_reg   <= hdr_idx_next;
            declared_reg  <= declared_next;
            emitted_reg   <= emitted_next;
            raw_phase_reg <= raw_phase_next;
            raw_low_reg   <= raw_low_next;
            overran_reg   <= overran_next;
            rep_cnt_reg   <= rep_cnt_next;
            rep_slide_reg <= rep_slide_next;
            rep_down_reg  <= rep_down_next;
            out_valid_reg <= out_valid_next;
            if (cmd.capture && byte_data.stream_start)
            begin
                tbl_valid_reg <= '0;
            end
            else if (tbl_we)
            begin
                tbl_valid_reg[tbl_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.capture)
        begin
            byte_reg  <= byte_data.data_byte;
            end_reg   <= byte_data.stream_end;
            rdata_reg <= tbl_mem[byte_data.data_byte[AW-1:0]];
        end
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= entry_val;
        end
    end

    assign stat.kind      = kind;
    assign stat.end_seen  = end_reg;
    assign stat.out_free  = out_free;
    assign stat.step_last = (rep_cnt_reg == '0);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= declared_reg)
        else $error("entry count passed declared count");

    a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
        overran_reg |-> (emitted_reg == declared_reg))
        else $error("overrun flagged before count reached");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status_item) |->
        (out_reg.end_of_group && out_reg.tile_entry == '0))
        else $error("status item malformed");

    a_capture_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && byte_data.stream_start) |=>
        (tbl_valid_reg == '0 && emitted_reg == '0 && !overran_reg))
        else $error("stream start did not clear state");

endmodule

`default_nettype wire
